FILE: rtl/core/oqnp_pkg.sv
// Package for the ordered queue node pool: sizes, command and status codes,
// and the control/status structs passed between the controller and the datapath.
// No dependencies.
`default_nettype none

package oqnp_pkg;

    localparam int POOL_SIZE = 16;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int NODE_W    = $clog2(POOL_SIZE + 1);
    localparam int CNT_W     = 5;
    localparam int DATA_W    = 32;

    localparam logic [NODE_W-1:0] NIL_NODE = NODE_W'(POOL_SIZE);
    localparam logic [CNT_W-1:0]  POOL_CNT = CNT_W'(POOL_SIZE);

    typedef enum logic [1:0] {
        CMD_INSERT      = 2'd0,
        CMD_REMOVE_HEAD = 2'd1,
        CMD_REMOVE_KEY  = 2'd2,
        CMD_REMOVE_LE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_TAKE_FREE,
        DP_ALLOC,
        DP_APPEND,
        DP_START_WALK,
        DP_STEP,
        DP_LINK_NODE,
        DP_SPLICE,
        DP_UNLINK,
        DP_RELEASE
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    finish;
        status_t result;
    } dp_ctrl_t;

    typedef struct packed {
        logic free_nil;
        logic q_empty;
        logic cur_nil;
        logic key_le;
        logic key_eq;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/oqnp_ctrl.sv
// Controller for the ordered queue node pool: sequences insert, walk and
// unlink steps. Depends on oqnp_pkg.
`default_nettype none

module oqnp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        command,
    input  wire logic              order_mode,
    input  wire oqnp_pkg::dp_stat_t stat,
    output oqnp_pkg::dp_ctrl_t     ctrl,
    output logic                   busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC,
        S_APPEND,
        S_WALK,
        S_SPLICE,
        S_SEARCH,
        S_CHECK,
        S_UNLINK,
        S_RELEASE
    } state_t;

    state_t         state_reg, state_next;
    oqnp_pkg::cmd_t cmd_reg;

    always_comb
    begin
        state_next  = state_reg;
        ctrl.op     = oqnp_pkg::DP_NONE;
        ctrl.finish = 1'b0;
        ctrl.result = oqnp_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.op    = oqnp_pkg::DP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (cmd_reg == oqnp_pkg::CMD_INSERT)
                begin
                    if (stat.free_nil)
                    begin
                        ctrl.finish = 1'b1;
                        ctrl.result = oqnp_pkg::ST_NO_FREE;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        ctrl.op    = oqnp_pkg::DP_TAKE_FREE;
                        state_next = S_ALLOC;
                    end
                end
                else if (stat.q_empty)
                begin
                    ctrl.finish = 1'b1;
                    ctrl.result = oqnp_pkg::ST_EMPTY;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctrl.op    = oqnp_pkg::DP_START_WALK;
                    state_next = (cmd_reg == oqnp_pkg::CMD_REMOVE_KEY) ? S_SEARCH : S_CHECK;
                end
            end
            S_ALLOC:
            begin
                // first entry of an empty queue is finished here
                ctrl.op = oqnp_pkg::DP_ALLOC;
                if (stat.q_empty)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (!order_mode)
                    state_next = S_APPEND;
                else
                    state_next = S_WALK;
            end
            S_APPEND:
            begin
                ctrl.op     = oqnp_pkg::DP_APPEND;
                ctrl.finish = 1'b1;
                state_next  = S_IDLE;
            end
            S_WALK:
            begin
                if (!stat.cur_nil && stat.key_le)
                    ctrl.op = oqnp_pkg::DP_STEP;
                else
                begin
                    ctrl.op    = oqnp_pkg::DP_LINK_NODE;
                    state_next = S_SPLICE;
                end
            end
            S_SPLICE:
            begin
                ctrl.op     = oqnp_pkg::DP_SPLICE;
                ctrl.finish = 1'b1;
                state_next  = S_IDLE;
            end
            S_SEARCH:
            begin
                if (stat.cur_nil)
                begin
                    ctrl.finish = 1'b1;
                    ctrl.result = oqnp_pkg::ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else if (stat.key_eq)
                    state_next = S_UNLINK;
                else
                    ctrl.op = oqnp_pkg::DP_STEP;
            end
            S_CHECK:
            begin
                if (cmd_reg == oqnp_pkg::CMD_REMOVE_LE && !stat.key_le)
                begin
                    ctrl.finish = 1'b1;
                    ctrl.result = oqnp_pkg::ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_UNLINK;
            end
            S_UNLINK:
            begin
                ctrl.op    = oqnp_pkg::DP_UNLINK;
                state_next = S_RELEASE;
            end
            S_RELEASE:
            begin
                ctrl.op     = oqnp_pkg::DP_RELEASE;
                ctrl.finish = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= oqnp_pkg::CMD_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && start)
                cmd_reg <= oqnp_pkg::cmd_t'(command);
        end
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    a_finish_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> state_reg == S_IDLE)
        else $error("controller did not return to idle after finishing");
    a_release_after_unlink: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RELEASE |-> $past(state_reg) == S_UNLINK)
        else $error("release without unlink");
    a_no_free_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.finish && ctrl.result == oqnp_pkg::ST_NO_FREE) |-> cmd_reg == oqnp_pkg::CMD_INSERT)
        else $error("no-free status on a removal");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/oqnp_datapath.sv
// Datapath for the ordered queue node pool: node arrays, free chain,
// queue pointers, walk registers and result registers. Depends on oqnp_pkg.
`default_nettype none

module oqnp_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire oqnp_pkg::dp_ctrl_t          ctrl,
    input  wire logic [oqnp_pkg::DATA_W-1:0] payload_in,
    input  wire logic [oqnp_pkg::DATA_W-1:0] key_in,
    output oqnp_pkg::dp_stat_t               stat,
    output logic                             result_valid,
    output logic [1:0]                       status,
    output logic [oqnp_pkg::DATA_W-1:0]      payload_out,
    output logic [oqnp_pkg::DATA_W-1:0]      key_out,
    output logic [oqnp_pkg::CNT_W-1:0]       occupancy
);

    logic [oqnp_pkg::DATA_W-1:0] payload_mem [oqnp_pkg::POOL_SIZE];
    logic [oqnp_pkg::DATA_W-1:0] key_mem     [oqnp_pkg::POOL_SIZE];
    logic [oqnp_pkg::NODE_W-1:0] link_reg    [oqnp_pkg::POOL_SIZE];

    logic [oqnp_pkg::NODE_W-1:0] free_head_reg, free_head_next;
    logic [oqnp_pkg::NODE_W-1:0] head_reg, head_next;
    logic [oqnp_pkg::NODE_W-1:0] tail_reg, tail_next;
    logic [oqnp_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [oqnp_pkg::NODE_W-1:0] cur_reg, cur_next;
    logic [oqnp_pkg::NODE_W-1:0] prev_reg, prev_next;
    logic [oqnp_pkg::NODE_W-1:0] node_reg, node_next;
    logic [oqnp_pkg::DATA_W-1:0] pay_reg;
    logic [oqnp_pkg::DATA_W-1:0] key_reg;

    logic                        done_reg;
    oqnp_pkg::status_t           status_reg;
    logic [oqnp_pkg::DATA_W-1:0] payload_out_reg;
    logic [oqnp_pkg::DATA_W-1:0] key_out_reg;
    logic [oqnp_pkg::CNT_W-1:0]  occ_reg;

    logic [oqnp_pkg::IDX_W-1:0]  cur_idx;
    logic [oqnp_pkg::NODE_W-1:0] cur_link;
    logic [oqnp_pkg::DATA_W-1:0] cur_key;
    logic [oqnp_pkg::DATA_W-1:0] cur_pay;

    logic                        link_we;
    logic [oqnp_pkg::IDX_W-1:0]  link_waddr;
    logic [oqnp_pkg::NODE_W-1:0] link_wdata;
    logic                        node_we;

    assign cur_idx  = cur_reg[oqnp_pkg::IDX_W-1:0];
    assign cur_link = link_reg[cur_idx];
    assign cur_key  = key_mem[cur_idx];
    assign cur_pay  = payload_mem[cur_idx];

    assign stat.free_nil = (free_head_reg == oqnp_pkg::NIL_NODE);
    assign stat.q_empty  = (count_reg == '0);
    assign stat.cur_nil  = (cur_reg == oqnp_pkg::NIL_NODE);
    assign stat.key_le   = (cur_key <= key_reg);
    assign stat.key_eq   = (cur_key == key_reg);

    always_comb
    begin
        free_head_next = free_head_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        node_next      = node_reg;
        link_we        = 1'b0;
        link_waddr     = cur_idx;
        link_wdata     = oqnp_pkg::NIL_NODE;
        node_we        = 1'b0;
        case (ctrl.op)
            oqnp_pkg::DP_TAKE_FREE:
            begin
                cur_next  = free_head_reg;
                node_next = free_head_reg;
            end
            oqnp_pkg::DP_ALLOC:
            begin
                // pop the free chain, fill the node, then aim the walk at the head
                free_head_next = cur_link;
                node_we        = 1'b1;
                link_we        = 1'b1;
                if (count_reg == '0)
                begin
                    head_next  = node_reg;
                    tail_next  = node_reg;
                    count_next = count_reg + oqnp_pkg::CNT_W'(1);
                end
                cur_next  = head_reg;
                prev_next = oqnp_pkg::NIL_NODE;
            end
            oqnp_pkg::DP_APPEND:
            begin
                link_we    = 1'b1;
                link_waddr = tail_reg[oqnp_pkg::IDX_W-1:0];
                link_wdata = node_reg;
                tail_next  = node_reg;
                count_next = count_reg + oqnp_pkg::CNT_W'(1);
            end
            oqnp_pkg::DP_START_WALK:
            begin
                cur_next  = head_reg;
                prev_next = oqnp_pkg::NIL_NODE;
            end
            oqnp_pkg::DP_STEP:
            begin
                prev_next = cur_reg;
                cur_next  = cur_link;
            end
            oqnp_pkg::DP_LINK_NODE:
            begin
                link_we    = 1'b1;
                link_waddr = node_reg[oqnp_pkg::IDX_W-1:0];
                link_wdata = cur_reg;
            end
            oqnp_pkg::DP_SPLICE:
            begin
                if (prev_reg == oqnp_pkg::NIL_NODE)
                    head_next = node_reg;
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[oqnp_pkg::IDX_W-1:0];
                    link_wdata = node_reg;
                end
                if (cur_reg == oqnp_pkg::NIL_NODE)
                    tail_next = node_reg;
                count_next = count_reg + oqnp_pkg::CNT_W'(1);
            end
            oqnp_pkg::DP_UNLINK:
            begin
                if (prev_reg == oqnp_pkg::NIL_NODE)
                    head_next = cur_link;
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[oqnp_pkg::IDX_W-1:0];
                    link_wdata = cur_link;
                end
                if (cur_link == oqnp_pkg::NIL_NODE)
                    tail_next = prev_reg;
                count_next = count_reg - oqnp_pkg::CNT_W'(1);
                if (count_reg == oqnp_pkg::CNT_W'(1))
                begin
                    head_next = oqnp_pkg::NIL_NODE;
                    tail_next = oqnp_pkg::NIL_NODE;
                end
            end
            oqnp_pkg::DP_RELEASE:
            begin
                // push the node on the front of the free chain
                link_we        = 1'b1;
                link_wdata     = free_head_reg;
                free_head_next = cur_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < oqnp_pkg::POOL_SIZE; i++)
                link_reg[i] <= oqnp_pkg::NODE_W'(i + 1);
            free_head_reg <= '0;
            head_reg      <= oqnp_pkg::NIL_NODE;
            tail_reg      <= oqnp_pkg::NIL_NODE;
            count_reg     <= '0;
            cur_reg       <= oqnp_pkg::NIL_NODE;
            prev_reg      <= oqnp_pkg::NIL_NODE;
            node_reg      <= oqnp_pkg::NIL_NODE;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (link_we)
                link_reg[link_waddr] <= link_wdata;
            free_head_reg <= free_head_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            node_reg      <= node_next;
            done_reg      <= ctrl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            payload_mem[cur_idx] <= pay_reg;
            key_mem[cur_idx]     <= key_reg;
        end
        if (ctrl.op == oqnp_pkg::DP_LATCH)
        begin
            pay_reg <= payload_in;
            key_reg <= key_in;
        end
        if (ctrl.finish)
        begin
            status_reg      <= ctrl.result;
            occ_reg         <= count_next;
            payload_out_reg <= (ctrl.op == oqnp_pkg::DP_RELEASE) ? cur_pay : '0;
            key_out_reg     <= (ctrl.op == oqnp_pkg::DP_RELEASE) ? cur_key : '0;
        end
    end

    assign result_valid = done_reg;
    assign status       = status_reg;
    assign payload_out  = payload_out_reg;
    assign key_out      = key_out_reg;
    assign occupancy    = occ_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= oqnp_pkg::POOL_CNT)
        else $error("entry count above pool size");
    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (head_reg == oqnp_pkg::NIL_NODE))
        else $error("head pointer disagrees with entry count");
    a_tail_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (tail_reg == oqnp_pkg::NIL_NODE))
        else $error("tail pointer disagrees with entry count");
    a_full_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == oqnp_pkg::POOL_CNT) |-> free_head_reg == oqnp_pkg::NIL_NODE)
        else $error("free chain not empty while queue full");
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ordered_queue_node_pool_top.sv
// Top level of the ordered queue node pool: configuration register port and
// the controller/datapath pair. Depends on oqnp_pkg, oqnp_ctrl, oqnp_datapath.
//
//  Channel   Signals                                   Transfer
//  --------  ----------------------------------------  --------------------------------
//  command   start, busy, command, payload_in, key_in  start && !busy at a rising edge
//  result    result_valid, status, payload_out,        one-cycle strobe, cannot stall
//            key_out, occupancy
//  config    psel, penable, pwrite, paddr, pwdata,     psel && penable && pwrite && pready
//            prdata, pready
//
// Sequencing: the result strobe rises after the accepting edge, and the next transaction
// can be accepted at the edge that ends the strobe. A missing free node or an empty queue
// answers from the dispatch state, an insert into an empty queue from the alloc state, a
// FIFO insert after alloc and append, and a head removal after dispatch, check, unlink and
// release. An ordered insert or a remove by key walks the list one node per cycle through
// the single read port of the node arrays. busy drops in the cycle the strobe shows.
// Reset: rst_n clears the controller, the pointers and chains every node into the free
// chain at once; no clearing pass is needed. Payload and key storage is not reset.
// The result side cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module ordered_queue_node_pool_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] payload_in,
    input  wire logic [31:0] key_in,
    // result channel
    output logic             result_valid,
    output logic [1:0]       status,
    output logic [31:0]      payload_out,
    output logic [31:0]      key_out,
    output logic [4:0]       occupancy,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic REG_ORDER_MODE = 1'b0;

    logic               order_mode_reg;
    logic               cfg_write;
    oqnp_pkg::dp_ctrl_t ctrl;
    oqnp_pkg::dp_stat_t stat;

    // Register index sits at paddr[2]; only index zero exists, others are dropped.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_mode_reg <= 1'b0;
        else if (cfg_write && paddr[2] == REG_ORDER_MODE)
            order_mode_reg <= pwdata[0];
    end

    // Return the mode on a read of index zero, zero for anything beyond.
    assign prdata = (paddr[2] == REG_ORDER_MODE) ? {31'd0, order_mode_reg} : 32'd0;

    oqnp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .order_mode (order_mode_reg),
        .stat       (stat),
        .ctrl       (ctrl),
        .busy       (busy)
    );

    oqnp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .payload_in   (payload_in),
        .key_in       (key_in),
        .stat         (stat),
        .result_valid (result_valid),
        .status       (status),
        .payload_out  (payload_out),
        .key_out      (key_out),
        .occupancy    (occupancy)
    );

`ifndef SYNTHESIS
    a_no_strobe_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_valid)
        else $error("result strobe right after accepting a transaction");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("controller not busy after accepting a transaction");
    a_mode_stable_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_write |=> $stable(order_mode_reg))
        else $error("order mode changed without a register write");
`endif

endmodule

`default_nettype wire
